/* rtl/core/knn_pkg.sv */
// Shared constants and word types of the k-nearest-neighbour classifier.
`default_nettype none
package knn_pkg;

   // Word field widths.
   localparam int OPCODE_WIDTH    = 2;
   localparam int INDEX_WIDTH     = 4;
   localparam int FEATURE_WIDTH   = 16;
   localparam int LABEL_WIDTH     = 8;
   localparam int CLASS_WIDTH     = 9;
   localparam int VOTE_WIDTH      = 4;

   // Sizes of the neighbour list and of the test point.
   localparam int K_MAX           = 8;
   localparam int DIM_MAX         = 16;
   localparam int SLOT_WIDTH      = (K_MAX > 1) ? $clog2(K_MAX) : 1;

   // Configuration registers.
   localparam int KCOUNT_WIDTH    = 4;
   localparam int DIMS_WIDTH      = 5;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_K_COUNT    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIMENSIONS = 1'b1;
   localparam logic [KCOUNT_WIDTH-1:0]    K_COUNT_RESET  = KCOUNT_WIDTH'(7);
   localparam logic [DIMS_WIDTH-1:0]      DIMS_RESET     = DIMS_WIDTH'(DIM_MAX);

   // Arithmetic widths.
   localparam int DIFF_WIDTH      = FEATURE_WIDTH + 1;
   localparam int SQUARE_WIDTH    = 2 * FEATURE_WIDTH;
   localparam int ACC_WIDTH       = 39;

   // Empty list slot.
   localparam logic [ACC_WIDTH-1:0]   EMPTY_DISTANCE = ACC_WIDTH'(999999);
   localparam logic [CLASS_WIDTH-1:0] EMPTY_LABEL    = '1;

   // Command queue between the front and the back end.
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_WIDTH      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   // Operation codes.
   localparam logic [OPCODE_WIDTH-1:0] OP_LOAD_TEST = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_TRAIN     = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_CLASSIFY  = 2'd2;

   // Request word.
   typedef struct packed {
      logic [OPCODE_WIDTH-1:0]         opcode;
      logic [INDEX_WIDTH-1:0]          feature_index;
      logic signed [FEATURE_WIDTH-1:0] feature_value;
      logic [LABEL_WIDTH-1:0]          point_label;
   } knn_req_type;

   // Response word.
   typedef struct packed {
      logic signed [CLASS_WIDTH-1:0] class_label;
      logic [VOTE_WIDTH-1:0]         vote_count;
   } knn_rsp_type;

   // Command handed from the front to the back end.
   typedef struct packed {
      logic                         classify;
      logic                         last;
      logic signed [DIFF_WIDTH-1:0] diff;
      logic [LABEL_WIDTH-1:0]       label;
   } knn_cmd_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } knn_qstat_type;

endpackage
`default_nettype wire

/* rtl/core/knn_queue.sv */
// Short command queue that decouples the front end from the back end.
`default_nettype none
module knn_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  knn_pkg::knn_cmd_type push_data,
   input  wire                  pop,
   output knn_pkg::knn_cmd_type pop_data,
   output knn_pkg::knn_qstat_type qstat
);
   import knn_pkg::*;

   knn_cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_WIDTH-1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data    = entries_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCOUNT_WIDTH'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCOUNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue fill count beyond its depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count did not grow on a push");
`endif

endmodule
`default_nettype wire

/* rtl/core/knn_front.sv */
// Front end: takes request words, holds the test point and queues training differences.
`default_nettype none
module knn_front (
   input  wire                          clock,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  knn_pkg::knn_req_type         req_data,
   input  wire [knn_pkg::DIMS_WIDTH-1:0] dims_reg,
   output logic                         push,
   output knn_pkg::knn_cmd_type         cmd,
   input  knn_pkg::knn_qstat_type       qstat
);
   import knn_pkg::*;

   logic signed [FEATURE_WIDTH-1:0] test_ff [DIM_MAX];
   logic signed [FEATURE_WIDTH-1:0] test_in;
   logic                            test_wr;
   logic [DIMS_WIDTH-1:0]           dims_eff;
   logic [DIMS_WIDTH-1:0]           index_ext;
   logic                            in_range;
   logic                            is_last;
   logic                            accept;

   // Clamp the dimension count to the supported range.
   always_comb begin
      if (dims_reg == '0) begin
         dims_eff = DIMS_WIDTH'(1);
      end else if (int'(dims_reg) > DIM_MAX) begin
         dims_eff = DIMS_WIDTH'(DIM_MAX);
      end else begin
         dims_eff = dims_reg;
      end
   end

   assign index_ext = DIMS_WIDTH'(req_data.feature_index);
   assign in_range  = (index_ext < dims_eff);
   assign is_last   = (index_ext == (dims_eff - DIMS_WIDTH'(1)));
   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;

   // Test features are stored directly; training and classify words enter the queue.
   assign test_wr = accept && (req_data.opcode == OP_LOAD_TEST) && in_range;
   assign test_in = req_data.feature_value;
   assign push    = accept && (((req_data.opcode == OP_TRAIN) && in_range)
                               || (req_data.opcode == OP_CLASSIFY));

   always_comb begin
      cmd.classify = (req_data.opcode == OP_CLASSIFY);
      cmd.last     = is_last;
      cmd.diff     = DIFF_WIDTH'(req_data.feature_value)
                     - DIFF_WIDTH'(test_ff[req_data.feature_index]);
      cmd.label    = req_data.point_label;
   end

   always_ff @(posedge clock) begin
      if (test_wr) begin
         test_ff[req_data.feature_index] <= test_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/knn_back.sv */
// Back end: square and accumulate pipeline, sorted neighbour list and vote sequencer.
`default_nettype none
module knn_back (
   input  wire                             clock,
   input  wire                             reset,
   input  wire [knn_pkg::KCOUNT_WIDTH-1:0] k_reg,
   output logic                            pop,
   input  knn_pkg::knn_cmd_type            cmd,
   input  knn_pkg::knn_qstat_type          qstat,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output knn_pkg::knn_rsp_type            rsp_data
);
   import knn_pkg::*;

   typedef enum logic [2:0] {
      V_IDLE = 3'b001,
      V_SCAN = 3'b010,
      V_DONE = 3'b100
   } vote_state_type;

   vote_state_type             vote_state_ff, vote_state_in;
   logic                       adv;
   logic [KCOUNT_WIDTH-1:0]    k_eff;

   // Square stage.
   logic                       p1_valid_ff, p1_valid_in;
   logic                       p1_classify_ff, p1_last_ff;
   logic [LABEL_WIDTH-1:0]     p1_label_ff;
   logic [SQUARE_WIDTH-1:0]    p1_sq_ff, p1_sq_in;
   logic [FEATURE_WIDTH-1:0]   mag;

   // Accumulate stage.
   logic [ACC_WIDTH-1:0]       acc_ff, acc_in;
   logic [ACC_WIDTH:0]         acc_sum;
   logic [ACC_WIDTH-1:0]       acc_sat;
   logic                       p2_insert_ff, p2_insert_in;
   logic                       p2_classify_ff, p2_classify_in;
   logic [ACC_WIDTH-1:0]       p2_dist_ff;
   logic [CLASS_WIDTH-1:0]     p2_label_ff;

   // Neighbour list.
   logic [ACC_WIDTH-1:0]       dist_ff [K_MAX];
   logic [ACC_WIDTH-1:0]       dist_in [K_MAX];
   logic [CLASS_WIDTH-1:0]     lab_ff  [K_MAX];
   logic [CLASS_WIDTH-1:0]     lab_in  [K_MAX];
   logic                       do_insert;
   logic                       do_clear;

   // Vote sequencer.
   logic [SLOT_WIDTH-1:0]      vote_idx_ff, vote_idx_in;
   logic [VOTE_WIDTH-1:0]      best_ff, best_in;
   logic [CLASS_WIDTH-1:0]     winner_ff, winner_in;
   logic [VOTE_WIDTH-1:0]      match_count;
   logic [CLASS_WIDTH-1:0]     cur_label;
   logic                       scan_end;

   // Response register.
   logic                       rsp_valid_ff, rsp_valid_in;
   knn_rsp_type                rsp_data_ff, rsp_data_in;
   logic                       rsp_load;

   // Clamp the neighbour count to the supported range.
   always_comb begin
      if (k_reg == '0) begin
         k_eff = KCOUNT_WIDTH'(1);
      end else if (int'(k_reg) > K_MAX) begin
         k_eff = KCOUNT_WIDTH'(K_MAX);
      end else begin
         k_eff = k_reg;
      end
   end

   // The pipeline freezes while a vote is running.
   assign adv = (vote_state_ff == V_IDLE);
   assign pop = adv && !qstat.empty;

   // Magnitude of the difference and its square.
   always_comb begin
      if (cmd.diff[DIFF_WIDTH-1]) begin
         mag = FEATURE_WIDTH'(-cmd.diff);
      end else begin
         mag = FEATURE_WIDTH'(cmd.diff);
      end
      p1_sq_in    = SQUARE_WIDTH'(mag) * SQUARE_WIDTH'(mag);
      p1_valid_in = pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p1_classify_ff <= cmd.classify;
         p1_last_ff     <= cmd.last;
         p1_label_ff    <= cmd.label;
         p1_sq_ff       <= p1_sq_in;
      end
   end

   // Saturating accumulation; the last feature hands the distance on and clears the sum.
   always_comb begin
      acc_sum        = {1'b0, acc_ff} + (ACC_WIDTH + 1)'(p1_sq_ff);
      acc_sat        = acc_sum[ACC_WIDTH] ? '1 : acc_sum[ACC_WIDTH-1:0];
      acc_in         = acc_ff;
      p2_insert_in   = 1'b0;
      p2_classify_in = 1'b0;
      if (p1_valid_ff) begin
         if (p1_classify_ff) begin
            p2_classify_in = 1'b1;
         end else if (p1_last_ff) begin
            acc_in       = '0;
            p2_insert_in = 1'b1;
         end else begin
            acc_in = acc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         p2_insert_ff   <= 1'b0;
         p2_classify_ff <= 1'b0;
      end else if (adv) begin
         acc_ff         <= acc_in;
         p2_insert_ff   <= p2_insert_in;
         p2_classify_ff <= p2_classify_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && p1_valid_ff) begin
         p2_dist_ff  <= acc_sat;
         p2_label_ff <= CLASS_WIDTH'(p1_label_ff);
      end
   end

   // Strict sorted insert: slots after the insert point shift down by one.
   assign do_insert = adv && p2_insert_ff;

   always_comb begin
      logic found;
      logic active;
      logic lt;
      found = 1'b0;
      for (int i = 0; i < K_MAX; i++) begin
         dist_in[i] = dist_ff[i];
         lab_in[i]  = lab_ff[i];
         active     = (i < int'(k_eff));
         lt         = (p2_dist_ff < dist_ff[i]);
         if (do_clear) begin
            dist_in[i] = EMPTY_DISTANCE;
            lab_in[i]  = EMPTY_LABEL;
         end else if (do_insert && active) begin
            if (found) begin
               dist_in[i] = dist_ff[(i > 0) ? i - 1 : 0];
               lab_in[i]  = lab_ff[(i > 0) ? i - 1 : 0];
            end else if (lt) begin
               dist_in[i] = p2_dist_ff;
               lab_in[i]  = p2_label_ff;
            end
         end
         found = found | (active & lt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < K_MAX; i++) begin
            dist_ff[i] <= EMPTY_DISTANCE;
            lab_ff[i]  <= EMPTY_LABEL;
         end
      end else begin
         for (int i = 0; i < K_MAX; i++) begin
            dist_ff[i] <= dist_in[i];
            lab_ff[i]  <= lab_in[i];
         end
      end
   end

   // Count later slots that hold the same label as the current one.
   assign cur_label = lab_ff[vote_idx_ff];

   always_comb begin
      match_count = VOTE_WIDTH'(1);
      for (int j = 0; j < K_MAX; j++) begin
         if ((j > int'(vote_idx_ff)) && (j < int'(k_eff)) && (lab_ff[j] == cur_label)) begin
            match_count = match_count + VOTE_WIDTH'(1);
         end
      end
   end

   assign scan_end = (KCOUNT_WIDTH'(vote_idx_ff) == (k_eff - KCOUNT_WIDTH'(1)));
   assign rsp_load = (vote_state_ff == V_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign do_clear = rsp_load;

   // Vote sequencer: one slot per cycle, then post the word and clear the list.
   always_comb begin
      vote_state_in = vote_state_ff;
      vote_idx_in   = vote_idx_ff;
      best_in       = best_ff;
      winner_in     = winner_ff;
      case (vote_state_ff)
         V_IDLE: begin
            if (p2_classify_ff) begin
               vote_state_in = V_SCAN;
               vote_idx_in   = '0;
               best_in       = VOTE_WIDTH'(1);
               winner_in     = lab_ff[0];
            end
         end
         V_SCAN: begin
            if (match_count > best_ff) begin
               best_in   = match_count;
               winner_in = cur_label;
            end
            if (scan_end) begin
               vote_state_in = V_DONE;
            end else begin
               vote_idx_in = vote_idx_ff + 1'b1;
            end
         end
         V_DONE: begin
            if (rsp_load) begin
               vote_state_in = V_IDLE;
            end
         end
         default: begin
            vote_state_in = V_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vote_state_ff <= V_IDLE;
      end else begin
         vote_state_ff <= vote_state_in;
      end
   end

   always_ff @(posedge clock) begin
      vote_idx_ff <= vote_idx_in;
      best_ff     <= best_in;
      winner_ff   <= winner_in;
   end

   // Output register lets a finished word wait while the pipeline carries on.
   always_comb begin
      rsp_valid_in            = rsp_valid_ff;
      rsp_data_in             = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.class_label = winner_ff;
         rsp_data_in.vote_count  = best_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_vote_clears_list: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && (lab_ff[0] == EMPTY_LABEL)
                    && (dist_ff[0] == EMPTY_DISTANCE)))
      else $error("list not cleared after a vote result was posted");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (adv && p1_valid_ff && !p1_classify_ff && p1_last_ff) |=> (acc_ff == '0))
      else $error("accumulator not cleared after the last feature of a point");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      (vote_state_ff == V_SCAN) |-> ((best_ff != '0) && (best_ff <= k_eff)))
      else $error("running vote count outside one to k");
`endif

endmodule
`default_nettype wire

/* rtl/core/knn_majority_classifier.sv */
// Top level of the k-nearest-neighbour majority classifier with its register port.
`default_nettype none
// k-nearest-neighbour classifier with squared Euclidean distance. Request words load
// test features, stream training features, or ask for a classification. The front end
// takes one word per cycle while its four-entry command queue has room; training
// differences then pass a square stage and a saturating accumulate stage at one word
// per cycle while no vote is running, and the last feature of a point is inserted
// into the sorted list of the k nearest. A classify word runs the vote sequencer,
// which scans each kept neighbour in turn (k of them, with k_count clamped to one
// through eight) and then posts the result; the back end holds its pipeline meanwhile
// and the queue absorbs further words. The result waits in an output register, so a
// stalled response does not block requests until the queue fills. Reset is synchronous
// and active high; registers are written through the csr_ port, which is always ready.
// The user must write them only while the block is idle; the block does not enforce it.
module knn_majority_classifier (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  knn_pkg::knn_req_type               req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output knn_pkg::knn_rsp_type               rsp_data,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [knn_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire [knn_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import knn_pkg::*;

   logic [KCOUNT_WIDTH-1:0] k_count_ff, k_count_in;
   logic [DIMS_WIDTH-1:0]   dims_ff, dims_in;
   logic                    push;
   logic                    pop;
   knn_cmd_type             push_cmd;
   knn_cmd_type             pop_cmd;
   knn_qstat_type           qstat;

   // Register writes.
   assign csr_ready = 1'b1;

   always_comb begin
      k_count_in = k_count_ff;
      dims_in    = dims_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_K_COUNT:    k_count_in = csr_data[KCOUNT_WIDTH-1:0];
            CSR_DIMENSIONS: dims_in    = csr_data[DIMS_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_count_ff <= K_COUNT_RESET;
         dims_ff    <= DIMS_RESET;
      end else begin
         k_count_ff <= k_count_in;
         dims_ff    <= dims_in;
      end
   end

   knn_front u_front (
      .clock     (clock),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .dims_reg  (dims_ff),
      .push      (push),
      .cmd       (push_cmd),
      .qstat     (qstat)
   );

   knn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .qstat     (qstat)
   );

   knn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .k_reg     (k_count_ff),
      .pop       (pop),
      .cmd       (pop_cmd),
      .qstat     (qstat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
